// ===== hdl/svpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the space vector PWM generator.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package svpg_pkg;

    localparam int ANGLE_BITS_DEF      = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [23:0] STEP_GAIN_RESET = 24'd503316;
    localparam logic [31:0] PI3_Q30         = 32'd1124419809;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;

    typedef struct packed {
        logic signed [15:0] frequency;
        logic signed [15:0] amplitude;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] duty_a;
        logic signed [15:0] duty_b;
        logic signed [15:0] duty_c;
        logic        [2:0]  sector;
    } out_word_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_STEP,
        MUL_T,
        MUL_SQ,
        MUL_RECIP,
        MUL_UA,
        MUL_XA
    } mul_op_t;

    typedef struct packed {
        logic        take_in;
        mul_op_t     mul_op;
        logic        upd_angle;
        logic        ld_t;
        logic        ld_u;
        logic        ld_v;
        logic        ld_a;
        logic [1:0]  div_idx;
        logic        ld_sine;
        logic        sine_sel;
        logic        ld_duty;
        logic        ld_scale;
        logic [1:0]  scale_idx;
    } cmd_t;

    // Taylor series divisors, innermost term first
    function automatic logic [6:0] div_const(input logic [1:0] idx);
        logic [6:0] d;
        case (idx)
            2'd0:    d = 7'd72;
            2'd1:    d = 7'd42;
            2'd2:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] div_recip(input logic [1:0] idx);
        logic [31:0] r;
        case (idx)
            2'd0:    r = 32'd59652323;
            2'd1:    r = 32'd102261126;
            2'd2:    r = 32'd214748364;
            default: r = 32'd715827882;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/svpg_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the space vector PWM generator: steps the datapath through
// angle update, two sine evaluations and duty scaling. Uses svpg_pkg.
module svpg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output svpg_pkg::cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_STEP = 15'b000000000000010,
        S_ANG  = 15'b000000000000100,
        S_TMUL = 15'b000000000001000,
        S_T    = 15'b000000000010000,
        S_SQ   = 15'b000000000100000,
        S_U    = 15'b000000001000000,
        S_D1   = 15'b000000010000000,
        S_D2   = 15'b000000100000000,
        S_UA   = 15'b000001000000000,
        S_UV   = 15'b000010000000000,
        S_FM   = 15'b000100000000000,
        S_FS   = 15'b001000000000000,
        S_DZ   = 15'b010000000000000,
        S_SC   = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] div_reg, div_next;
    logic       sine_reg, sine_next;
    logic [1:0] sc_reg, sc_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_next       = div_reg;
        sine_next      = sine_reg;
        sc_next        = sc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_op     = svpg_pkg::MUL_NONE;
        cmd.div_idx    = div_reg;
        cmd.sine_sel   = sine_reg;
        cmd.scale_idx  = sc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.mul_op = svpg_pkg::MUL_STEP;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                cmd.upd_angle = 1'b1;
                state_next    = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul_op = svpg_pkg::MUL_T;
                state_next = S_T;
            end
            S_T:
            begin
                cmd.ld_t   = 1'b1;
                sine_next  = 1'b0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_op = svpg_pkg::MUL_SQ;
                state_next = S_U;
            end
            S_U:
            begin
                cmd.ld_u   = 1'b1;
                div_next   = 2'd0;
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd.mul_op = svpg_pkg::MUL_RECIP;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.ld_a = 1'b1;
                if (div_reg == 2'd3)
                begin
                    state_next = S_FM;
                end
                else
                begin
                    div_next   = div_reg + 2'd1;
                    state_next = S_UA;
                end
            end
            S_UA:
            begin
                cmd.mul_op = svpg_pkg::MUL_UA;
                state_next = S_UV;
            end
            S_UV:
            begin
                cmd.ld_v   = 1'b1;
                state_next = S_D1;
            end
            S_FM:
            begin
                cmd.mul_op = svpg_pkg::MUL_XA;
                state_next = S_FS;
            end
            S_FS:
            begin
                cmd.ld_sine = 1'b1;
                if (!sine_reg)
                begin
                    sine_next  = 1'b1;
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = S_DZ;
                end
            end
            S_DZ:
            begin
                // hold until the previous word has left the output register
                if (!(out_valid_reg && !out_ready))
                begin
                    cmd.ld_duty = 1'b1;
                    sc_next     = 2'd0;
                    state_next  = S_SC;
                end
            end
            S_SC:
            begin
                cmd.ld_scale = 1'b1;
                if (sc_reg == 2'd2)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    sc_next = sc_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_reg       <= 2'd0;
            sine_reg      <= 1'b0;
            sc_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_reg       <= div_next;
            sine_reg      <= sine_next;
            sc_reg        <= sc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/svpg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the space vector PWM generator: angle state, shared 32x32
// multiplier, constant dividers, duty assignment and scaling. Uses svpg_pkg.
module svpg_datapath #(
    parameter int ANGLE_BITS      = svpg_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = svpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [23:0]          cfg_data,
    input  svpg_pkg::in_word_t   in_word,
    input  svpg_pkg::cmd_t       cmd,
    output svpg_pkg::out_word_t  out_word
);

    localparam int SHIFT = 39 - ANGLE_BITS;
    localparam int DROP  = (ANGLE_BITS > SINE_TABLE_BITS) ? ANGLE_BITS - SINE_TABLE_BITS : 0;

    logic [23:0]           gain_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic [2:0]            cnt_reg;
    svpg_pkg::in_word_t    in_reg;
    logic [63:0]           mul_reg;
    logic [30:0]           t_reg, x_reg, u_reg, v_reg, a_reg;
    logic [16:0]           dy_reg, dx_reg;
    logic [16:0]           ta_reg, tb_reg, tc_reg;
    svpg_pkg::out_word_t   out_reg;

    logic [31:0]           mul_a, mul_b;
    logic [16:0]           fabs;
    logic signed [41:0]    sprod, step;
    logic [ANGLE_BITS-1:0] nw, qang;
    logic [28:0]           q0, qc;
    logic [6:0]            dconst;
    logic [35:0]           qd, rem;
    logic [31:0]           srnd;
    logic signed [18:0]    dz_full;
    logic [15:0]           dz;
    logic [16:0]           na, nb, nc;
    logic [16:0]           dsel;
    logic signed [18:0]    d2;
    logic signed [16:0]    gain;
    logic signed [36:0]    sprd;
    logic signed [36:0]    shr;
    logic signed [15:0]    sat;

    assign out_word = out_reg;

    always_comb
    begin
        fabs   = in_reg.frequency[15] ? 17'(-$signed({in_reg.frequency[15], in_reg.frequency}))
                                      : 17'($signed(in_reg.frequency));
        qang   = (ang_reg >> DROP) << DROP;
        dconst = svpg_pkg::div_const(cmd.div_idx);
        unique case (cmd.mul_op)
            svpg_pkg::MUL_STEP:
            begin
                mul_a = 32'(gain_reg);
                mul_b = 32'(fabs);
            end
            svpg_pkg::MUL_T:
            begin
                mul_a = 32'(qang);
                mul_b = svpg_pkg::PI3_Q30;
            end
            svpg_pkg::MUL_SQ:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            svpg_pkg::MUL_RECIP:
            begin
                mul_a = 32'(v_reg);
                mul_b = svpg_pkg::div_recip(cmd.div_idx);
            end
            svpg_pkg::MUL_UA:
            begin
                mul_a = 32'(u_reg);
                mul_b = 32'(a_reg);
            end
            svpg_pkg::MUL_XA:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(a_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // signed step with floor rounding
        sprod = in_reg.frequency[15] ? -$signed({1'b0, mul_reg[40:0]})
                                     : $signed({1'b0, mul_reg[40:0]});
        step  = sprod >>> SHIFT;
        nw    = ang_reg + step[ANGLE_BITS-1:0];

        // quotient estimate is low by at most one
        q0  = mul_reg[60:32];
        qd  = 36'(q0) * 36'(dconst);
        rem = 36'(v_reg) - qd;
        qc  = q0 + 29'(rem >= 36'(dconst));

        srnd = (32'(mul_reg[60:30]) + 32'd16384) >> 15;

        dz_full = 19'sd32768 - $signed({2'b00, dx_reg}) - $signed({2'b00, dy_reg});
        dz      = dz_full[18] ? 16'd0 : dz_full[16:1];
        unique case (cnt_reg)
            3'd1:
            begin
                nb = 17'(dz);
                na = 17'(dz) + dy_reg;
                nc = 17'd32768 - 17'(dz);
            end
            3'd2:
            begin
                nb = 17'(dz);
                nc = 17'(dz) + dx_reg;
                na = 17'd32768 - 17'(dz);
            end
            3'd3:
            begin
                nc = 17'(dz);
                nb = 17'(dz) + dy_reg;
                na = 17'd32768 - 17'(dz);
            end
            3'd4:
            begin
                nc = 17'(dz);
                na = 17'(dz) + dx_reg;
                nb = 17'd32768 - 17'(dz);
            end
            3'd5:
            begin
                na = 17'(dz);
                nc = 17'(dz) + dy_reg;
                nb = 17'd32768 - 17'(dz);
            end
            default:
            begin
                na = 17'(dz);
                nb = 17'(dz) + dx_reg;
                nc = 17'd32768 - 17'(dz);
            end
        endcase

        unique case (cmd.scale_idx)
            2'd0:    dsel = ta_reg;
            2'd1:    dsel = tb_reg;
            default: dsel = tc_reg;
        endcase
        d2   = $signed({1'b0, dsel, 1'b0}) - 19'sd32768;
        gain = in_reg.amplitude[15] ? 17'sd0 : $signed({2'b00, in_reg.amplitude[14:0]});
        sprd = 37'(d2) * 37'(gain) + 37'sd16384;
        shr  = sprd >>> 15;
        if (shr > 37'sd32767)
        begin
            sat = 16'sd32767;
        end
        else if (shr < -37'sd32768)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = shr[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= svpg_pkg::STEP_GAIN_RESET;
            ang_reg  <= '0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_data;
            end
            if (cmd.upd_angle)
            begin
                ang_reg <= nw;
                if (nw < ang_reg)
                begin
                    cnt_reg <= (cnt_reg < 3'd5) ? cnt_reg + 3'd1 : 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);
        if (cmd.take_in)
        begin
            in_reg <= in_word;
        end
        if (cmd.ld_t)
        begin
            t_reg <= mul_reg[ANGLE_BITS +: 31];
            x_reg <= mul_reg[ANGLE_BITS +: 31];
        end
        if (cmd.ld_u)
        begin
            u_reg <= mul_reg[60:30];
            v_reg <= mul_reg[60:30];
        end
        if (cmd.ld_v)
        begin
            v_reg <= mul_reg[60:30];
        end
        if (cmd.ld_a)
        begin
            a_reg <= svpg_pkg::ONE_Q30 - 31'(qc);
        end
        if (cmd.ld_sine)
        begin
            if (!cmd.sine_sel)
            begin
                dy_reg <= srnd[16:0];
                x_reg  <= 31'(svpg_pkg::PI3_Q30) - t_reg;
            end
            else
            begin
                dx_reg <= srnd[16:0];
            end
        end
        if (cmd.ld_duty)
        begin
            ta_reg <= na;
            tb_reg <= nb;
            tc_reg <= nc;
        end
        if (cmd.ld_scale)
        begin
            unique case (cmd.scale_idx)
                2'd0:    out_reg.duty_a <= sat;
                2'd1:    out_reg.duty_b <= sat;
                default:
                begin
                    out_reg.duty_c <= sat;
                    out_reg.sector <= cnt_reg;
                end
            endcase
        end
    end

endmodule

// ===== hdl/space_vector_pwm_generator.sv =====
`timescale 1ns / 1ps
// Space vector PWM generator: one input word (frequency, amplitude) per PWM
// period gives one output word (three phase duties and the sector index).
// Built from svpg_ctrl and svpg_datapath; types and constants from svpg_pkg.
//
// in_valid/in_ready take a word; out_valid/out_ready deliver the result.
// Each word goes from acceptance to out_valid through the angle step, the two
// sine evaluations and the duties. The single shared 32x32 multiplier is used
// for every product, so these steps run one after another.
// A new input word is taken as soon as the previous one is finished, even
// while its result still waits in the output register; the following result
// holds before its duty scaling until that register is free.
// cfg_we writes step_gain from cfg_data in the same cycle; write it only idle.
// Reset clears the angle, the sector counter and all handshake state and
// restores step_gain to its default.
module space_vector_pwm_generator #(
    parameter int ANGLE_BITS      = svpg_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = svpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  svpg_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output svpg_pkg::out_word_t out_word
);

    svpg_pkg::cmd_t cmd;

    svpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    svpg_datapath #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_word  (in_word),
        .cmd      (cmd),
        .out_word (out_word)
    );

endmodule

// ===== tb/svpg_checker.sv =====
`timescale 1ns / 1ps
// Checker for the space vector PWM generator: predicts each output word from the
// accepted input words and compares. Depends on svpg_pkg only.
module svpg_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  svpg_pkg::in_word_t  in_word,
    input  logic                out_valid,
    input  logic                out_ready,
    input  svpg_pkg::out_word_t out_word,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen
);

    localparam longint PI3 = 64'd1124419809;
    localparam longint ONE = 64'd1073741824;

    logic [23:0]         gain_reg;
    logic [23:0]         angle;
    logic [2:0]          sect;
    svpg_pkg::out_word_t duty_q[$];

    function automatic int sine15(longint unsigned t);
        longint unsigned u, a;
        u = (t * t) >> 30;
        a = ONE - u / 72;
        a = ONE - ((u * a) >> 30) / 42;
        a = ONE - ((u * a) >> 30) / 20;
        a = ONE - ((u * a) >> 30) / 6;
        return int'((((t * a) >> 30) + 16384) >> 15);
    endfunction

    function automatic logic [15:0] scale_duty(int d, int g);
        longint p;
        p = longint'(2 * d - 32768) * g + 16384;
        p = p >>> 15;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    task automatic predict_duties(svpg_pkg::in_word_t w);
        longint prod, stp;
        logic [23:0] nw, q;
        longint unsigned t;
        int dx, dy, dz, ta, tb, tc, g;
        svpg_pkg::out_word_t r;
        prod = longint'(gain_reg) * longint'(w.frequency);
        stp = prod >>> 15;
        nw = angle + stp[23:0];
        q = {nw[23:14], 14'd0};
        t = (longint'(q) * PI3) >> 24;
        dy = sine15(t);
        dx = sine15(PI3 - t);
        dz = 32768 - dx - dy;
        if (dz < 0) dz = 0;
        dz = dz >>> 1;
        if (nw < angle) sect = (sect < 5) ? sect + 3'd1 : 3'd0;
        angle = nw;
        case (sect)
            3'd1: begin tb = dz; ta = tb + dy; tc = 32768 - tb; end
            3'd2: begin tb = dz; tc = tb + dx; ta = 32768 - tb; end
            3'd3: begin tc = dz; tb = tc + dy; ta = 32768 - tc; end
            3'd4: begin tc = dz; ta = tc + dx; tb = 32768 - tc; end
            3'd5: begin ta = dz; tc = ta + dy; tb = 32768 - ta; end
            default: begin ta = dz; tb = ta + dx; tc = 32768 - ta; end
        endcase
        g = (w.amplitude < 0) ? 0 : int'(w.amplitude);
        r.duty_a = scale_duty(ta, g);
        r.duty_b = scale_duty(tb, g);
        r.duty_c = scale_duty(tc, g);
        r.sector = sect;
        duty_q.push_back(r);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        svpg_pkg::out_word_t e;
        if (!rst_n)
        begin
            gain_reg = svpg_pkg::STEP_GAIN_RESET;
            angle = '0;
            sect = '0;
            duty_q.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
                gain_reg = cfg_data;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (duty_q.size() == 0)
                    report("unexpected word", 0, 0);
                else
                begin
                    e = duty_q.pop_front();
                    if (out_word.duty_a !== e.duty_a) report("duty_a", out_word.duty_a, e.duty_a);
                    if (out_word.duty_b !== e.duty_b) report("duty_b", out_word.duty_b, e.duty_b);
                    if (out_word.duty_c !== e.duty_c) report("duty_c", out_word.duty_c, e.duty_c);
                    if (out_word.sector !== e.sector) report("sector", out_word.sector, e.sector);
                end
            end
            if (in_valid && in_ready)
                predict_duties(in_word);
        end
        pending = duty_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the space vector PWM generator testbench: clock, reset, stimulus and verdict.
// Depends on svpg_pkg, the block and svpg_checker.
module tb;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [23:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    svpg_pkg::in_word_t  in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    svpg_pkg::out_word_t out_word;
    int                  fail_count, pending, results_seen;
    int                  idle_cycles = 0;
    int                  words_sent = 0;

    always #2 clk = ~clk;

    space_vector_pwm_generator u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    svpg_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // receiver stall pattern: phases of free flow and of random stalls
    always @(posedge clk)
    begin
        int ph;
        ph = (results_seen / 40) % 3;
        if (ph == 0) out_ready <= 1'b1;
        else if (ph == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 7) == 0);
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000)
        begin
            $display("timeout");
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_word(logic [15:0] f, logic [15:0] a);
        in_valid <= 1'b1;
        in_word.frequency <= f;
        in_word.amplitude <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_gain(logic [23:0] g);
        cfg_we <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random frequency: mostly moderate, sometimes any value
    function automatic logic [15:0] pick_freq();
        if ($urandom_range(0, 4) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 16000) - 4000);
    endfunction

    task automatic random_burst(int n);
        int left, gap;
        left = n;
        while (left > 0)
        begin
            int len;
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                if (left > 0)
                begin
                    send_word(pick_freq(), 16'($urandom()));
                    left--;
                end
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [23:0] gains[6];
        gains = '{24'd503316, 24'hFFFFFF, 24'd0, 24'd1, 24'h800000, 24'd2000000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: field extremes, backward steps, amplitude clamp
        send_word(16'sd0, 16'sd32767);
        send_word(16'sd32767, 16'sd32767);
        send_word(16'sh8000, 16'sd16384);
        send_word(16'sd32767, 16'sh8000);
        send_word(16'shFFFF, 16'shFFFF);
        send_word(16'sd1, 16'sd0);
        for (int i = 0; i < 14; i++)
            send_word(16'sd30000, i[0] ? 16'sd32767 : 16'sd20000);
        send_word(16'sh8001, 16'sd1);
        send_word(16'sh8000, 16'sd32767);
        drain();
        write_gain(24'hFFFFFF);
        send_word(16'sd32767, 16'sd32767);
        send_word(16'sh8000, 16'sd32767);
        send_word(16'sd12345, 16'sh7FFE);
        drain();
        for (int p = 0; p < 6; p++)
        begin
            write_gain(gains[p] == 24'd503316 ? 24'($urandom()) : gains[p]);
            random_burst(220);
            drain();
        end
        write_gain(24'd503316);
        random_burst(30);
        drain();
        $display("covered %0d input words, %0d results, seven step gain settings",
                 words_sent, results_seen);
        $display("extremes of gain, frequency and amplitude with random gaps and stalls");
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/svpg_pkg.sv
hdl/svpg_ctrl.sv
hdl/svpg_datapath.sv
hdl/space_vector_pwm_generator.sv
tb/svpg_checker.sv
tb/tb.sv
